/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mps_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mps_pkg
// request, result and config types, phase codes and speed duty table
// ---------------------------------------------------------------------------
package mps_pkg;

    localparam int HV_W       = 10;
    localparam int STEP_W     = 4;
    localparam int DUTY_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int TABLE_DEPTH = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_HV_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd1;

    localparam logic [HV_W-1:0]   HV_THRESHOLD_RESET = 10'd532;
    localparam logic [STEP_W-1:0] MAX_STEP_RESET     = 4'd11;
    localparam logic [STEP_W-1:0] TABLE_LAST         = 4'd11;

    localparam logic [DUTY_W-1:0] DUTY_TABLE [TABLE_DEPTH] = '{
        10'h000, 10'h031, 10'h042, 10'h053, 10'h064, 10'h075,
        10'h086, 10'h097, 10'h0A8, 10'h0BA, 10'h0CB, 10'h0DC
    };

    typedef enum logic [1:0] {
        PH_CHARGE = 2'd0,
        PH_POWER  = 2'd1,
        PH_RUN    = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic            speed_up_pin;
        logic            speed_down_pin;
        logic            user_power_pin;
        logic [HV_W-1:0] hv_sample;
    } t_in_req;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              power_permit;
        logic              drive_enable;
        logic              led_on;
        logic              feedback_level;
        logic [1:0]        phase_now;
        logic [STEP_W-1:0] speed_step;
    } t_out_res;

    typedef struct packed {
        logic [HV_W-1:0]   hv_threshold;
        logic [STEP_W-1:0] max_step;
    } t_cfg;

    function automatic logic [DUTY_W-1:0] duty_lookup(input logic [STEP_W-1:0] step);
        logic [STEP_W-1:0] idx;
        idx = (step > TABLE_LAST) ? TABLE_LAST : step;
        return DUTY_TABLE[idx];
    endfunction

endpackage

/* rtl/mps_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mps_core
// phase sequencer, button and power histories, speed step counter;
// state advances once per processed request, result built from next state
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mps_core #(
    parameter int HISTORY_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mps_pkg::t_in_req  i_req,
    input  mps_pkg::t_cfg     i_cfg,
    output mps_pkg::t_out_res o_res
);
    import mps_pkg::*;

    localparam logic [HISTORY_BITS-1:0] HistPress   = {1'b1, {(HISTORY_BITS-1){1'b0}}};
    localparam logic [HISTORY_BITS-1:0] HistPowerOn = {1'b0, {(HISTORY_BITS-1){1'b1}}};

    t_phase                  r_phase, n_phase;
    logic [HISTORY_BITS-1:0] r_pwr_hist, n_pwr_hist;
    logic [HISTORY_BITS-1:0] r_up_hist, n_up_hist;
    logic [HISTORY_BITS-1:0] r_dn_hist, n_dn_hist;
    logic [STEP_W-1:0]       r_step, n_step;
    logic                    r_feedback, n_feedback;
    logic [STEP_W-1:0]       step_mid;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_pwr_hist = r_pwr_hist;
        n_up_hist  = r_up_hist;
        n_dn_hist  = r_dn_hist;
        n_step     = r_step;
        n_feedback = r_feedback;
        step_mid   = r_step;
        case (r_phase)
            PH_CHARGE: begin
                if (i_req.hv_sample > i_cfg.hv_threshold) begin
                    n_feedback = 1'b0;
                    n_phase    = PH_POWER;
                end
            end
            PH_POWER: begin
                n_pwr_hist = {r_pwr_hist[HISTORY_BITS-2:0], i_req.user_power_pin};
                if (n_pwr_hist == HistPowerOn) begin
                    n_phase = PH_RUN;
                end
            end
            PH_RUN: begin
                if (!i_req.user_power_pin) begin
                    n_phase = PH_STOP;
                end else begin
                    n_feedback = 1'b1;
                    n_up_hist  = {r_up_hist[HISTORY_BITS-2:0], i_req.speed_up_pin};
                    n_dn_hist  = {r_dn_hist[HISTORY_BITS-2:0], i_req.speed_down_pin};
                    if ((n_up_hist == HistPress) && (r_step < i_cfg.max_step)) begin
                        step_mid = r_step + 1'b1;
                    end
                    n_step = step_mid;
                    if ((n_dn_hist == HistPress) && (step_mid != '0)) begin
                        n_step = step_mid - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result from post-tick state
    always_comb begin
        o_res.duty           = (n_phase == PH_RUN) ? duty_lookup(n_step) : '0;
        o_res.power_permit   = (n_phase == PH_POWER) || (n_phase == PH_RUN);
        o_res.drive_enable   = (n_phase == PH_RUN);
        o_res.led_on         = (n_phase != PH_STOP);
        o_res.feedback_level = n_feedback;
        o_res.phase_now      = n_phase;
        o_res.speed_step     = n_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CHARGE;
            r_pwr_hist <= '0;
            r_up_hist  <= '1;
            r_dn_hist  <= '1;
            r_step     <= '0;
            r_feedback <= 1'b1;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_pwr_hist <= n_pwr_hist;
            r_up_hist  <= n_up_hist;
            r_dn_hist  <= n_dn_hist;
            r_step     <= n_step;
            r_feedback <= n_feedback;
        end
    end

    `MPS_ASSERT_NEXT(a_stop_holds, r_phase == PH_STOP, r_phase == PH_STOP, "stopped phase left")
    `MPS_ASSERT_NEXT(a_idle_holds, !i_fire, $stable(r_phase) && $stable(r_step), "state moved without request")
    `MPS_ASSERT_NEXT(a_charge_exit, r_phase == PH_CHARGE, r_phase == PH_CHARGE || r_phase == PH_POWER, "charge phase skipped power-on")

endmodule

/* rtl/motor_power_sequencer_speed_stepper_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_power_sequencer_speed_stepper_unit
// motor power sequencer with debounced speed stepper, one poll tick per request
// ---------------------------------------------------------------------------
// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_ready     | i_in_req  (t_in_req)
// out     | output    | o_out_valid / i_out_ready   | o_out_res (t_out_res)
// cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one request per cycle sustained while results are taken
// (input register loaded at accept, result register when the request fires)
// a stalled result holds; one more request waits in the input register
// synchronous active-low reset, no clearing pass; config always ready
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_power_sequencer_speed_stepper_unit #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mps_pkg::t_in_req                  i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mps_pkg::t_out_res                 o_out_res,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mps_pkg::*;

    logic              r_in_valid;
    t_in_req           r_in_req;
    logic              r_out_valid;
    t_out_res          r_out_res;
    logic [HV_W-1:0]   r_hv_threshold;
    logic [STEP_W-1:0] r_max_step;
    t_cfg              cfg;
    t_out_res          core_res;
    logic              fire;
    logic              in_accept;
    logic              cfg_accept;

    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || fire;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    assign cfg.hv_threshold = r_hv_threshold;
    assign cfg.max_step     = r_max_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv_threshold <= HV_THRESHOLD_RESET;
            r_max_step     <= MAX_STEP_RESET;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                CFG_HV_THRESHOLD: r_hv_threshold <= i_cfg_data[HV_W-1:0];
                CFG_MAX_STEP:     r_max_step     <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res <= core_res;
        end
    end

    mps_core #(
        .HISTORY_BITS(HISTORY_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in_req),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    `MPS_ASSERT_NEXT(a_fire_gives_result, fire, r_out_valid, "processed request gave no result")
    `MPS_ASSERT_NOW(a_fire_needs_room, fire, !r_out_valid || i_out_ready,
        "result register overwritten")
    `MPS_ASSERT_NEXT(a_held_request, r_in_valid && !fire, r_in_valid && $stable(r_in_req),
        "queued request lost")

endmodule

/* bench/mps_sequencer_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mps_sequencer_checker
// passive monitor for the motor power sequencer: follows the register channel,
// predicts the status of every accepted poll request from its own copy of the
// phase, histories and speed step, and compares each accepted result field by
// field against the oldest prediction
// ---------------------------------------------------------------------------
module mps_sequencer_checker #(
    parameter int HISTORY_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  mps_pkg::t_in_req               i_in_req,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  mps_pkg::t_out_res              i_out_res,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [mps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_top_step
);
    import mps_pkg::*;

    localparam logic [HISTORY_BITS-1:0] PRESS_PATTERN = {1'b1, {(HISTORY_BITS-1){1'b0}}};
    localparam logic [HISTORY_BITS-1:0] START_PATTERN = {1'b0, {(HISTORY_BITS-1){1'b1}}};
    localparam logic [HISTORY_BITS-1:0] RELEASED      = {HISTORY_BITS{1'b1}};
    localparam logic [STEP_W-1:0]       LAST_ENTRY    = 4'd11;
    localparam logic [DUTY_W-1:0]       SPEED_DUTY [12] = '{
        10'h000, 10'h031, 10'h042, 10'h053, 10'h064, 10'h075,
        10'h086, 10'h097, 10'h0A8, 10'h0BA, 10'h0CB, 10'h0DC
    };

    logic [HV_W-1:0]         hv_threshold;
    logic [STEP_W-1:0]       step_limit;
    t_phase                  phase;
    logic [HISTORY_BITS-1:0] power_hist;
    logic [HISTORY_BITS-1:0] up_hist;
    logic [HISTORY_BITS-1:0] down_hist;
    logic [STEP_W-1:0]       step;
    logic                    feedback;
    t_out_res                expected_status [$];
    int                      fail_count = 0;
    int                      checked = 0;
    int                      top_step = 0;

    task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            report(what, want, got);
        end
    endtask

    task automatic predict_tick(input t_in_req req, output t_out_res res);
        logic [STEP_W-1:0] idx;
        case (phase)
            PH_CHARGE: begin
                if (req.hv_sample > hv_threshold) begin
                    feedback = 1'b0;
                    phase = PH_POWER;
                end
            end
            PH_POWER: begin
                power_hist = {power_hist[HISTORY_BITS-2:0], req.user_power_pin};
                if (power_hist == START_PATTERN) begin
                    phase = PH_RUN;
                end
            end
            PH_RUN: begin
                if (!req.user_power_pin) begin
                    phase = PH_STOP;
                end else begin
                    feedback = 1'b1;
                    up_hist = {up_hist[HISTORY_BITS-2:0], req.speed_up_pin};
                    down_hist = {down_hist[HISTORY_BITS-2:0], req.speed_down_pin};
                    if (up_hist == PRESS_PATTERN && step < step_limit) begin
                        step = step + 1'b1;
                    end
                    if (down_hist == PRESS_PATTERN && step > 0) begin
                        step = step - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        idx = (step > LAST_ENTRY) ? LAST_ENTRY : step;
        res.duty           = (phase == PH_RUN) ? SPEED_DUTY[idx] : '0;
        res.power_permit   = (phase == PH_POWER || phase == PH_RUN);
        res.drive_enable   = (phase == PH_RUN);
        res.led_on         = (phase != PH_STOP);
        res.feedback_level = feedback;
        res.phase_now      = phase;
        res.speed_step     = step;
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_out_res predicted;
        if (!i_rst_n) begin
            hv_threshold = HV_THRESHOLD_RESET;
            step_limit = MAX_STEP_RESET;
            phase = PH_CHARGE;
            power_hist = '0;
            up_hist = RELEASED;
            down_hist = RELEASED;
            step = '0;
            feedback = 1'b1;
            expected_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HV_THRESHOLD: hv_threshold = i_cfg_data;
                    CFG_MAX_STEP:     step_limit = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_status.size() == 0) begin
                    report("unexpected result", '0, 16'(i_out_res.speed_step));
                end else begin
                    predicted = expected_status.pop_front();
                    checked++;
                    check_field("duty", 16'(predicted.duty), 16'(i_out_res.duty));
                    check_field("power_permit", 16'(predicted.power_permit),
                                16'(i_out_res.power_permit));
                    check_field("drive_enable", 16'(predicted.drive_enable),
                                16'(i_out_res.drive_enable));
                    check_field("led_on", 16'(predicted.led_on), 16'(i_out_res.led_on));
                    check_field("feedback_level", 16'(predicted.feedback_level),
                                16'(i_out_res.feedback_level));
                    check_field("phase_now", 16'(predicted.phase_now),
                                16'(i_out_res.phase_now));
                    check_field("speed_step", 16'(predicted.speed_step),
                                16'(i_out_res.speed_step));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_in_req, predicted);
                expected_status.push_back(predicted);
                if (int'(step) > top_step) begin
                    top_step = int'(step);
                end
            end
        end
        o_fail_count = fail_count;
        o_pending = expected_status.size();
        o_checked = checked;
        o_top_step = top_step;
    end

endmodule

/* bench/motor_power_sequencer_speed_stepper_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_power_sequencer_speed_stepper_unit_test
// drives poll requests and register writes into the sequencer: a directed walk
// through charge, power-on and the first button presses, then long runs of
// debounced press gestures with bounce and noise under several speed-step
// limits, varying idle and stall pressure, and finally the power drop that
// stops the block; checking is done by the attached checker
// ---------------------------------------------------------------------------
module motor_power_sequencer_speed_stepper_unit_test;
    import mps_pkg::*;

    localparam int HISTORY_BITS = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int MODE_SPAN    = 64;
    localparam int RUN_LIMIT_NS = 400_000;
    localparam int NO_HOLD      = -1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_req               i_in_req;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_res              o_out_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int top_step;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int holds_done = 0;
    int ticks_sent = 0;
    int reg_writes = 0;
    int up_left = 0;
    int down_left = 0;

    motor_power_sequencer_speed_stepper_unit #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    mps_sequencer_checker #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_req     (i_in_req),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_res    (o_out_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_top_step   (top_step)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("motor_power_sequencer_speed_stepper_unit_test failed");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_in_req make_req(input logic up, input logic down, input logic user,
                                         input logic [HV_W-1:0] hv);
        t_in_req req;
        req.speed_up_pin = up;
        req.speed_down_pin = down;
        req.user_power_pin = user;
        req.hv_sample = hv;
        return req;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] step_limit_word(input int limit);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'($urandom);
        word[STEP_W-1:0] = STEP_W'(limit);
        return word;
    endfunction

    function automatic int press_length();
        if ($urandom_range(99) < 75) begin
            return $urandom_range(12, 7);
        end
        return $urandom_range(6, 1);
    endfunction

    task automatic send_tick(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        reg_writes++;
    endtask

    // press gestures on both buttons while user power stays up
    task automatic run_ticks(input int count, input int up_bias, input int hold_at);
        t_in_req req;
        int k;
        int len;
        for (k = 0; k < count; k++) begin
            case ((k / MODE_SPAN) % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 30;
                    recv_stall_pct = 30;
                end
            endcase
            if (k == hold_at) begin
                send_idle_pct = 0;
                hold_request = 1'b1;
            end
            if (up_left == 0 && down_left == 0 && $urandom_range(99) < 5) begin
                len = press_length();
                up_left = len;
                down_left = len;
            end
            if (up_left == 0 && $urandom_range(399) < up_bias) begin
                up_left = press_length();
            end
            if (down_left == 0 && $urandom_range(399) < 100 - up_bias) begin
                down_left = press_length();
            end
            req = make_req(up_left == 0, down_left == 0, 1'b1, HV_W'($urandom));
            if (up_left > 0) begin
                up_left--;
            end
            if (down_left > 0) begin
                down_left--;
            end
            if ($urandom_range(99) < 8) begin
                req.speed_up_pin = 1'($urandom);
                req.speed_down_pin = 1'($urandom);
            end
            send_tick(req);
        end
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // charge phase against the highest threshold, nothing can exceed it
        write_reg(CFG_HV_THRESHOLD, 10'h3FF);
        write_reg(CFG_MAX_STEP, 10'h3FF);
        send_tick(make_req(1'b1, 1'b1, 1'b0, 10'h3FF));
        send_tick(make_req(1'b0, 1'b0, 1'b1, 10'h000));
        send_tick(make_req(1'b1, 1'b0, 1'b1, 10'h2AA));
        send_tick(make_req(1'b0, 1'b1, 1'b0, 10'h155));

        // lowest threshold: zero does not exceed it, one does
        write_reg(CFG_HV_THRESHOLD, 10'h000);
        send_tick(make_req(1'b1, 1'b1, 1'b1, 10'h000));
        send_tick(make_req(1'b1, 1'b1, 1'b0, 10'h001));

        // power-on: a broken sequence, then the start pattern
        send_tick(make_req(1'b0, 1'b0, 1'b1, HV_W'($urandom)));
        send_tick(make_req(1'b0, 1'b0, 1'b1, HV_W'($urandom)));
        send_tick(make_req(1'b0, 1'b0, 1'b1, HV_W'($urandom)));
        send_tick(make_req(1'b0, 1'b0, 1'b0, HV_W'($urandom)));
        for (k = 0; k < HISTORY_BITS - 1; k++) begin
            send_tick(make_req(1'b0, 1'b0, 1'b1, HV_W'($urandom)));
        end

        // run: overlapping up and down presses, both long enough to land, up first and then down
        for (k = 1; k <= HISTORY_BITS; k++) begin
            send_tick(make_req(k >= HISTORY_BITS, k < 2, 1'b1, HV_W'($urandom)));
        end

        write_reg(CFG_MAX_STEP, step_limit_word(15));
        run_ticks(400, 95, 120);

        // limit lowered from 15 to 5
        write_reg(CFG_MAX_STEP, step_limit_word(5));
        run_ticks(250, 50, NO_HOLD);

        write_reg(CFG_MAX_STEP, step_limit_word(0));
        run_ticks(150, 20, NO_HOLD);

        write_reg(CFG_MAX_STEP, step_limit_word(11));
        run_ticks(300, 60, NO_HOLD);

        write_reg(CFG_HV_THRESHOLD, CFG_DATA_W'($urandom));
        write_reg(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
        write_reg(CFG_MAX_STEP, step_limit_word($urandom_range(15)));
        run_ticks(250, 50, NO_HOLD);

        write_reg(CFG_HV_THRESHOLD, HV_THRESHOLD_RESET);
        write_reg(CFG_MAX_STEP, step_limit_word(11));
        run_ticks(200, 10, NO_HOLD);

        // user power drop, then requests that the stopped block ignores
        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_tick(make_req(1'($urandom), 1'($urandom), 1'b0, HV_W'($urandom)));
        for (k = 0; k < 20; k++) begin
            send_tick(make_req(1'($urandom), 1'($urandom), 1'($urandom), HV_W'($urandom)));
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        $display("run covered %0d poll requests, %0d register writes, %0d results compared",
                 ticks_sent, reg_writes, checked);
        $display("walked charge, power-on, run and stop; top speed step %0d, %0d long holds",
                 top_step, holds_done);
        if (fail_count == 0 && pending == 0) begin
            $display("motor_power_sequencer_speed_stepper_unit_test passed");
        end else begin
            $display("motor_power_sequencer_speed_stepper_unit_test failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_core.sv
rtl/motor_power_sequencer_speed_stepper_unit.sv
bench/mps_sequencer_checker.sv
bench/motor_power_sequencer_speed_stepper_unit_test.sv
